@@ design/tpe_pkg.sv @@
// shared constants for the track plane extrapolation block
`default_nettype none

package tpe_pkg;

  localparam int unsigned CoordW     = 32;
  localparam int unsigned NumHits    = 8;
  localparam int unsigned NumLanes   = 4;
  localparam int unsigned InDataW    = NumHits * CoordW;
  localparam int unsigned OutDataW   = 10 * CoordW;
  localparam int unsigned CoordFracBitsDef = 16;

  // configuration register indexes
  localparam int unsigned RegIdxW = 3;
  localparam logic [RegIdxW-1:0] REG_PLANE_IN_FIRST_Z   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_PLANE_IN_SECOND_Z  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_PLANE_OUT_FIRST_Z  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_PLANE_OUT_SECOND_Z = 3'd3;
  localparam logic [RegIdxW-1:0] REG_REF_IN_Z           = 3'd4;
  localparam logic [RegIdxW-1:0] REG_REF_OUT_Z          = 3'd5;

  // extrapolation divider: 33 quotient bits over a 33 bit divisor
  localparam int unsigned ExtW  = 33;
  localparam int unsigned ExtQW = 33;
  // square root: one result bit per step over a 64 bit radicand
  localparam int unsigned SqW     = 64;
  localparam int unsigned SqSteps = 32;
  // direction divider: 31 quotient bits over a 32 bit root
  localparam int unsigned NrmW  = 32;
  localparam int unsigned NrmQW = 31;

  typedef struct packed {
    logic adv;
  } tpe_ctrl_t;

endpackage

`default_nettype wire

@@ design/tpe_div_cell.sv @@
// one restoring division step, remainder and quotient share a shift word
`default_nettype none

module tpe_div_cell
  import tpe_pkg::*;
#(
  parameter int unsigned W = ExtW,
  parameter int unsigned N = ExtQW
) (
  input  wire logic         clk_i,
  input  wire tpe_ctrl_t    ctrl_i,
  input  wire logic [W-1:0] d_i,
  input  wire logic [W-1:0] r_i,
  input  wire logic [N-1:0] lo_i,
  output logic      [W-1:0] d_o,
  output logic      [W-1:0] r_o,
  output logic      [N-1:0] lo_o
);

  logic [W:0]   t;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] r_d, r_q, d_q;
  logic [N-1:0] lo_d, lo_q;

  always_comb begin
    t    = {r_i, lo_i[N-1]};
    diff = t - {1'b0, d_i};
    ge   = (t >= {1'b0, d_i});
    r_d  = ge ? diff[W-1:0] : t[W-1:0];
    lo_d = {lo_i[N-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      d_q  <= d_i;
      r_q  <= r_d;
      lo_q <= lo_d;
    end
  end

  assign d_o  = d_q;
  assign r_o  = r_q;
  assign lo_o = lo_q;

endmodule

`default_nettype wire

@@ design/tpe_sqrt_cell.sv @@
// one step of the bitwise integer square root
`default_nettype none

module tpe_sqrt_cell
  import tpe_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  wire logic          clk_i,
  input  wire tpe_ctrl_t     ctrl_i,
  input  wire logic [SqW-1:0] s_i,
  input  wire logic [SqW-1:0] r_i,
  output logic      [SqW-1:0] s_o,
  output logic      [SqW-1:0] r_o
);

  localparam logic [SqW-1:0] Bit = SqW'(1) << (SqW - 2 - 2 * STEP);

  logic [SqW-1:0] t, s_d, r_d, s_q, r_q;
  logic           ge;

  always_comb begin
    t   = r_i + Bit;
    ge  = (s_i >= t);
    s_d = ge ? (s_i - t) : s_i;
    r_d = ge ? ((r_i >> 1) + Bit) : (r_i >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      s_q <= s_d;
      r_q <= r_d;
    end
  end

  assign s_o = s_q;
  assign r_o = r_q;

endmodule

`default_nettype wire

@@ design/tpe_delay.sv @@
// stalling shift line that keeps side data aligned with the cell chains
`default_nettype none

module tpe_delay
  import tpe_pkg::*;
#(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  wire logic         clk_i,
  input  wire tpe_ctrl_t    ctrl_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[N-1];

endmodule

`default_nettype wire

@@ design/track_plane_extrapolation.sv @@
// top level: two-track plane extrapolation and direction normalization pipeline
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata: hit_a_x .. hit_d_y, 8 x 32 bit
//  m_axis    out  m_axis_tvalid/tready        tdata: entry/exit x,y, dirs; tuser: error
//  cfg       in   cfg_we_i (no handshake)     cfg_idx_i selects, cfg_data_i value
//
//  one word per cycle sustained while m_axis is not stalled, 71 register stages: R1 to R6,
//  the square root chain, the direction divider setup and chain, then the output register
//  latency is set by the square root chain (32 cells) followed by the
//  direction divider chain (31 cells); the extrapolation dividers run alongside
//  reset clears the valid bits and loads the default plane positions
//  a stall on m_axis freezes the whole pipeline; the output register lets the
//  input side accept whenever that register is empty or being drained
`default_nettype none

module track_plane_extrapolation
  import tpe_pkg::*;
#(
  parameter int unsigned COORD_FRAC_BITS = CoordFracBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // hit_a_x, hit_a_y, hit_b_x, hit_b_y, hit_c_x, hit_c_y, hit_d_x, hit_d_y
  input  wire logic [InDataW-1:0]    s_axis_tdata,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // entry_x, entry_y, exit_x, exit_y, dir_in_x/y/z, dir_out_x/y/z
  output logic      [OutDataW-1:0]   m_axis_tdata,
  // geometry_error
  output logic                       m_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic                  cfg_we_i,
  input  wire logic [RegIdxW-1:0]    cfg_idx_i,
  input  wire logic [CoordW-1:0]     cfg_data_i
);

  // stage bookkeeping
  localparam int unsigned ExtEnd   = 4 + ExtQW;
  localparam int unsigned SqEnd    = 6 + SqSteps;
  localparam int unsigned NdivEnd  = SqEnd + 1 + NrmQW;
  localparam int unsigned QDly     = NdivEnd - ExtEnd;
  localparam int unsigned MDly     = SqEnd - 4;
  localparam int unsigned PackDly  = NdivEnd - 4;
  localparam int unsigned PackW    = NumLanes * CoordW + 3 * NumLanes + 6;
  localparam int unsigned MW       = NrmQW;

  localparam logic [CoordW-1:0] One   = CoordW'(1) << COORD_FRAC_BITS;
  localparam logic [CoordW-1:0] Two   = One << 1;
  localparam logic [CoordW-1:0] Three = One + Two;

  localparam logic signed [CoordW-1:0] SatMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] SatMin = {1'b1, {(CoordW-1){1'b0}}};

  tpe_ctrl_t ctrl;
  logic      adv;
  logic      out_vld_q;
  logic [NdivEnd-1:0] vld_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign ctrl.adv      = adv;
  assign s_axis_tready = adv;

  // configuration registers
  logic signed [CoordW-1:0] pif_q, pis_q, pof_q, pos_q, rin_q, rout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pif_q  <= '0;
      pis_q  <= One;
      pof_q  <= Two;
      pos_q  <= Three;
      rin_q  <= One;
      rout_q <= Two;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PLANE_IN_FIRST_Z:   pif_q  <= cfg_data_i;
        REG_PLANE_IN_SECOND_Z:  pis_q  <= cfg_data_i;
        REG_PLANE_OUT_FIRST_Z:  pof_q  <= cfg_data_i;
        REG_PLANE_OUT_SECOND_Z: pos_q  <= cfg_data_i;
        REG_REF_IN_Z:           rin_q  <= cfg_data_i;
        REG_REF_OUT_Z:          rout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid line and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NdivEnd-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[NdivEnd-1];
    end
  end

  // ---------------------------------------------------------------- R1: differences
  logic signed [CoordW-1:0] hit [NumHits];
  logic signed [CoordW:0]   comp_d [2][3];
  logic signed [CoordW:0]   num_d [2];
  logic signed [CoordW:0]   comp_q [2][3];
  logic signed [CoordW:0]   num_q [2];
  logic signed [CoordW-1:0] base1_q [NumLanes];

  always_comb begin
    for (int i = 0; i < NumHits; i++) begin
      hit[i] = s_axis_tdata[i*CoordW +: CoordW];
    end
    // incoming track: b - a, outgoing track: d - c
    comp_d[0][0] = (CoordW+1)'(hit[2]) - (CoordW+1)'(hit[0]);
    comp_d[0][1] = (CoordW+1)'(hit[3]) - (CoordW+1)'(hit[1]);
    comp_d[0][2] = (CoordW+1)'(pis_q) - (CoordW+1)'(pif_q);
    comp_d[1][0] = (CoordW+1)'(hit[6]) - (CoordW+1)'(hit[4]);
    comp_d[1][1] = (CoordW+1)'(hit[7]) - (CoordW+1)'(hit[5]);
    comp_d[1][2] = (CoordW+1)'(pos_q) - (CoordW+1)'(pof_q);
    num_d[0]     = (CoordW+1)'(rin_q) - (CoordW+1)'(pif_q);
    num_d[1]     = (CoordW+1)'(rout_q) - (CoordW+1)'(pos_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      comp_q     <= comp_d;
      num_q      <= num_d;
      base1_q[0] <= hit[0];
      base1_q[1] <= hit[1];
      base1_q[2] <= hit[6];
      base1_q[3] <= hit[7];
    end
  end

  // ---------------------------------------------------------------- R2: magnitudes
  logic [CoordW:0]          mag_d [2][3];
  logic [CoordW:0]          mag2_q [2][3];
  logic                     sgn2_q [2][3];
  logic [CoordW:0]          nmag2_q [2];
  logic                     nneg2_q [2];
  logic                     err2_q [2];
  logic [CoordW:0]          mx_d [2];
  logic [CoordW:0]          mx2_q [2];
  logic signed [CoordW-1:0] base2_q [NumLanes];

  always_comb begin
    for (int t = 0; t < 2; t++) begin
      for (int c = 0; c < 3; c++) begin
        mag_d[t][c] = comp_q[t][c][CoordW] ? (CoordW+1)'(-comp_q[t][c])
                                           : (CoordW+1)'(comp_q[t][c]);
      end
      mx_d[t] = mag_d[t][0];
      if (mag_d[t][1] > mx_d[t]) mx_d[t] = mag_d[t][1];
      if (mag_d[t][2] > mx_d[t]) mx_d[t] = mag_d[t][2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int t = 0; t < 2; t++) begin
        for (int c = 0; c < 3; c++) begin
          mag2_q[t][c] <= mag_d[t][c];
          sgn2_q[t][c] <= comp_q[t][c][CoordW];
        end
        nmag2_q[t] <= num_q[t][CoordW] ? (CoordW+1)'(-num_q[t]) : (CoordW+1)'(num_q[t]);
        nneg2_q[t] <= num_q[t][CoordW];
        err2_q[t]  <= (comp_q[t][2] == '0);
        mx2_q[t]   <= mx_d[t];
      end
      base2_q <= base1_q;
    end
  end

  // ---------------------------------------------------------------- R3: products, msb search
  logic [2*(CoordW+1)-1:0]  prod3_q [NumLanes];
  logic                     neg3_q [NumLanes];
  logic [5:0]               msb_d [2];
  logic [5:0]               msb3_q [2];
  logic                     zero3_q [2];
  logic [CoordW:0]          mag3_q [2][3];
  logic                     sgn3_q [2][3];
  logic                     err3_q [2];
  logic signed [CoordW-1:0] base3_q [NumLanes];

  always_comb begin
    for (int t = 0; t < 2; t++) begin
      msb_d[t] = '0;
      for (int i = 0; i <= CoordW; i++) begin
        if (mx2_q[t][i]) msb_d[t] = 6'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < NumLanes; l++) begin
        prod3_q[l] <= (2*(CoordW+1))'(nmag2_q[l/2]) * (2*(CoordW+1))'(mag2_q[l/2][l%2]);
        neg3_q[l]  <= nneg2_q[l/2] ^ sgn2_q[l/2][l%2] ^ sgn2_q[l/2][2];
      end
      for (int t = 0; t < 2; t++) begin
        msb3_q[t]  <= msb_d[t];
        zero3_q[t] <= (mx2_q[t] == '0);
      end
      mag3_q  <= mag2_q;
      sgn3_q  <= sgn2_q;
      err3_q  <= err2_q;
      base3_q <= base2_q;
    end
  end

  // ---------------------------------------------------------------- R4: divider setup, scaling
  logic [2*(CoordW+1)-1:0] dvd_d [NumLanes];
  logic [ExtW-1:0]         er4_q [NumLanes];
  logic [ExtQW-1:0]        elo4_q [NumLanes];
  logic [ExtW-1:0]         ed4_q [NumLanes];
  logic                    ovf4_q [NumLanes];
  logic                    neg4_q [NumLanes];
  logic [CoordW:0]         sh_d [2][3];
  logic [MW-1:0]           m4_q [2][3];
  logic                    sgn4_q [2][3];
  logic                    zero4_q [2];
  logic                    err4_q [2];
  logic signed [CoordW-1:0] base4_q [NumLanes];

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      dvd_d[l] = prod3_q[l] + (2*(CoordW+1))'(mag3_q[l/2][2] >> 1);
    end
    for (int t = 0; t < 2; t++) begin
      for (int c = 0; c < 3; c++) begin
        if (msb3_q[t] > 6'd30) begin
          sh_d[t][c] = mag3_q[t][c] >> (msb3_q[t] - 6'd30);
        end else begin
          sh_d[t][c] = mag3_q[t][c] << (6'd30 - msb3_q[t]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < NumLanes; l++) begin
        er4_q[l]  <= dvd_d[l][2*(CoordW+1)-1 -: ExtW];
        elo4_q[l] <= dvd_d[l][ExtQW-1:0];
        ed4_q[l]  <= mag3_q[l/2][2];
        // quotient would reach 2^33: saturates whatever the base, unless the planes coincide
        ovf4_q[l] <= (dvd_d[l][2*(CoordW+1)-1 -: ExtW] >= mag3_q[l/2][2]);
      end
      for (int t = 0; t < 2; t++) begin
        for (int c = 0; c < 3; c++) begin
          m4_q[t][c] <= sh_d[t][c][MW-1:0];
        end
      end
      neg4_q  <= neg3_q;
      sgn4_q  <= sgn3_q;
      zero4_q <= zero3_q;
      err4_q  <= err3_q;
      base4_q <= base3_q;
    end
  end

  // side data carried to the output stage
  logic [PackW-1:0] pack_d, pack_q;

  always_comb begin
    pack_d = '0;
    for (int l = 0; l < NumLanes; l++) begin
      pack_d[l*CoordW +: CoordW]           = base4_q[l];
      pack_d[NumLanes*CoordW + l]          = neg4_q[l];
      pack_d[NumLanes*CoordW + NumLanes + l] = ovf4_q[l];
    end
    for (int t = 0; t < 2; t++) begin
      pack_d[NumLanes*CoordW + 2*NumLanes + t] = err4_q[t];
      pack_d[NumLanes*CoordW + 2*NumLanes + 2 + t] = zero4_q[t];
      for (int c = 0; c < 3; c++) begin
        pack_d[NumLanes*CoordW + 2*NumLanes + 4 + t*3 + c] = sgn4_q[t][c];
      end
    end
  end

  tpe_delay #(.W(PackW), .N(PackDly)) u_pack_dly (
    .clk_i (clk_i),
    .ctrl_i(ctrl),
    .d_i   (pack_d),
    .q_o   (pack_q)
  );

  // ---------------------------------------------------------------- extrapolation dividers
  logic [ExtW-1:0]  ecd [NumLanes][ExtQW+1];
  logic [ExtW-1:0]  ecr [NumLanes][ExtQW+1];
  logic [ExtQW-1:0] ecl [NumLanes][ExtQW+1];
  logic [ExtQW-1:0] eq_q [NumLanes];

  for (genvar l = 0; l < NumLanes; l++) begin : g_ext
    assign ecd[l][0] = ed4_q[l];
    assign ecr[l][0] = er4_q[l];
    assign ecl[l][0] = elo4_q[l];
    for (genvar k = 0; k < ExtQW; k++) begin : g_cell
      tpe_div_cell #(.W(ExtW), .N(ExtQW)) u_cell (
        .clk_i (clk_i),
        .ctrl_i(ctrl),
        .d_i   (ecd[l][k]),
        .r_i   (ecr[l][k]),
        .lo_i  (ecl[l][k]),
        .d_o   (ecd[l][k+1]),
        .r_o   (ecr[l][k+1]),
        .lo_o  (ecl[l][k+1])
      );
    end
    tpe_delay #(.W(ExtQW), .N(QDly)) u_q_dly (
      .clk_i (clk_i),
      .ctrl_i(ctrl),
      .d_i   (ecl[l][ExtQW]),
      .q_o   (eq_q[l])
    );
  end

  // ---------------------------------------------------------------- R5/R6: squares, sum
  logic [2*MW-1:0] sq5_q [2][3];
  logic [SqW-1:0]  sum6_q [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int t = 0; t < 2; t++) begin
        for (int c = 0; c < 3; c++) begin
          sq5_q[t][c] <= (2*MW)'(m4_q[t][c]) * (2*MW)'(m4_q[t][c]);
        end
        sum6_q[t] <= SqW'(sq5_q[t][0]) + SqW'(sq5_q[t][1]) + SqW'(sq5_q[t][2]);
      end
    end
  end

  // ---------------------------------------------------------------- square root chains
  logic [SqW-1:0] scs [2][SqSteps+1];
  logic [SqW-1:0] scr [2][SqSteps+1];
  logic [3*MW-1:0] mpk_d [2];
  logic [3*MW-1:0] mpk_q [2];

  for (genvar t = 0; t < 2; t++) begin : g_sq
    assign scs[t][0] = sum6_q[t];
    assign scr[t][0] = '0;
    for (genvar k = 0; k < SqSteps; k++) begin : g_cell
      tpe_sqrt_cell #(.STEP(k)) u_cell (
        .clk_i (clk_i),
        .ctrl_i(ctrl),
        .s_i   (scs[t][k]),
        .r_i   (scr[t][k]),
        .s_o   (scs[t][k+1]),
        .r_o   (scr[t][k+1])
      );
    end
    assign mpk_d[t] = {m4_q[t][2], m4_q[t][1], m4_q[t][0]};
    tpe_delay #(.W(3*MW), .N(MDly)) u_m_dly (
      .clk_i (clk_i),
      .ctrl_i(ctrl),
      .d_i   (mpk_d[t]),
      .q_o   (mpk_q[t])
    );
  end

  // ---------------------------------------------------------------- direction divider setup
  logic [NrmW+MW-1:0] ndvd_d [2][3];
  logic [NrmW-1:0]    nd_q [2][3];
  logic [NrmW-1:0]    nr_q [2][3];
  logic [NrmQW-1:0]   nlo_q [2][3];

  always_comb begin
    for (int t = 0; t < 2; t++) begin
      for (int c = 0; c < 3; c++) begin
        ndvd_d[t][c] = ((NrmW+MW)'(mpk_q[t][c*MW +: MW]) << 30)
                     + (NrmW+MW)'(scr[t][SqSteps][NrmW-1:1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int t = 0; t < 2; t++) begin
        for (int c = 0; c < 3; c++) begin
          nd_q[t][c]  <= scr[t][SqSteps][NrmW-1:0];
          nr_q[t][c]  <= NrmW'(ndvd_d[t][c][NrmW+MW-1:NrmQW]);
          nlo_q[t][c] <= ndvd_d[t][c][NrmQW-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------- direction dividers
  logic [NrmW-1:0]  ncd [6][NrmQW+1];
  logic [NrmW-1:0]  ncr [6][NrmQW+1];
  logic [NrmQW-1:0] ncl [6][NrmQW+1];

  for (genvar j = 0; j < 6; j++) begin : g_nrm
    assign ncd[j][0] = nd_q[j/3][j%3];
    assign ncr[j][0] = nr_q[j/3][j%3];
    assign ncl[j][0] = nlo_q[j/3][j%3];
    for (genvar k = 0; k < NrmQW; k++) begin : g_cell
      tpe_div_cell #(.W(NrmW), .N(NrmQW)) u_cell (
        .clk_i (clk_i),
        .ctrl_i(ctrl),
        .d_i   (ncd[j][k]),
        .r_i   (ncr[j][k]),
        .lo_i  (ncl[j][k]),
        .d_o   (ncd[j][k+1]),
        .r_o   (ncr[j][k+1]),
        .lo_o  (ncl[j][k+1])
      );
    end
  end

  // ---------------------------------------------------------------- output stage
  logic [OutDataW-1:0]      odata_d, odata_q;
  logic                     oerr_d, oerr_q;
  logic signed [CoordW+2:0] esum;
  logic signed [CoordW-1:0] pos_v;
  logic                     l_err, l_neg, l_ovf;
  logic [CoordW-1:0]        dir_v;
  logic [CoordW-1:0]        qn;

  always_comb begin
    odata_d = '0;
    esum    = '0;
    pos_v   = '0;
    l_err   = 1'b0;
    l_neg   = 1'b0;
    l_ovf   = 1'b0;
    dir_v   = '0;
    qn      = '0;
    for (int l = 0; l < NumLanes; l++) begin
      l_err = pack_q[NumLanes*CoordW + 2*NumLanes + l/2];
      l_neg = pack_q[NumLanes*CoordW + l];
      l_ovf = pack_q[NumLanes*CoordW + NumLanes + l];
      esum  = (CoordW+3)'($signed(pack_q[l*CoordW +: CoordW]));
      if (l_neg) begin
        esum = esum - (CoordW+3)'(eq_q[l]);
      end else begin
        esum = esum + (CoordW+3)'(eq_q[l]);
      end
      if (l_err) begin
        // planes coincide: base hit passes unchanged
        pos_v = pack_q[l*CoordW +: CoordW];
      end else if (l_ovf) begin
        pos_v = l_neg ? SatMin : SatMax;
      end else if (esum > (CoordW+3)'(SatMax)) begin
        pos_v = SatMax;
      end else if (esum < (CoordW+3)'(SatMin)) begin
        pos_v = SatMin;
      end else begin
        pos_v = esum[CoordW-1:0];
      end
      odata_d[l*CoordW +: CoordW] = pos_v;
    end
    for (int j = 0; j < 6; j++) begin
      qn = CoordW'(ncl[j][NrmQW]);
      if (pack_q[NumLanes*CoordW + 2*NumLanes + 2 + j/3]) begin
        dir_v = '0;
      end else if (pack_q[NumLanes*CoordW + 2*NumLanes + 4 + j]) begin
        dir_v = -qn;
      end else begin
        dir_v = qn;
      end
      odata_d[(NumLanes + j)*CoordW +: CoordW] = dir_v;
    end
    oerr_d = pack_q[NumLanes*CoordW + 2*NumLanes] | pack_q[NumLanes*CoordW + 2*NumLanes + 1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      odata_q <= odata_d;
      oerr_q  <= oerr_d;
    end
  end

  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = oerr_q;
  assign m_axis_tvalid = out_vld_q;

endmodule

`default_nettype wire

@@ design/tpe_checker.sv @@
// port-level checks for the track plane extrapolation block
`default_nettype none

module tpe_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tready,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [319:0] m_axis_tdata
);

  localparam logic signed [31:0] UnitPos = 32'sd1073741824;
  localparam logic signed [31:0] UnitNeg = -32'sd1073741824;

  // a held word stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");

  // input side only waits when the output register is full and stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output register state");

  a_dir_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      $signed(m_axis_tdata[159:128]) <= UnitPos && $signed(m_axis_tdata[159:128]) >= UnitNeg &&
      $signed(m_axis_tdata[191:160]) <= UnitPos && $signed(m_axis_tdata[191:160]) >= UnitNeg &&
      $signed(m_axis_tdata[223:192]) <= UnitPos && $signed(m_axis_tdata[223:192]) >= UnitNeg)
    else $error("incoming direction beyond unit length");

  a_dir_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      $signed(m_axis_tdata[255:224]) <= UnitPos && $signed(m_axis_tdata[255:224]) >= UnitNeg &&
      $signed(m_axis_tdata[287:256]) <= UnitPos && $signed(m_axis_tdata[287:256]) >= UnitNeg &&
      $signed(m_axis_tdata[319:288]) <= UnitPos && $signed(m_axis_tdata[319:288]) >= UnitNeg)
    else $error("outgoing direction beyond unit length");

endmodule

bind track_plane_extrapolation tpe_checker u_tpe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
